// ===== design/lfcd_pkg.sv =====
package lfcd_pkg;

  localparam logic [7:0]  StartByte   = 8'h23;  // '#'
  localparam logic [7:0]  SepByte     = 8'h7C;  // '|'
  localparam logic [7:0]  NulByte     = 8'h00;
  localparam logic [15:0] HeaderLen   = 16'd3;
  localparam logic [15:0] ResetMaxLen = 16'd1024;
  localparam int          MaxResults  = 3;

  typedef enum logic [2:0] {
    KIND_CMD_BYTE  = 3'd0,
    KIND_CMD_END   = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_BAD_START = 3'd3,
    KIND_TRUNC     = 3'd4,
    KIND_BAD_LEN   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  // Results caused by one input word, slot 0 goes out first.
  typedef struct packed {
    logic [1:0]           count;
    res_t [MaxResults-1:0] slot;
  } grp_t;

endpackage

// ===== design/length_framed_command_deframer.sv =====
// Length-framed command deframer. Bytes arrive one per word on the slave
// stream (tdata = data byte, tuser = chunk start flag). A frame is '#', a
// 16-bit big-endian total length that includes the three header bytes, then
// the payload, which is cut at '|' into commands (empty ones skipped) and
// ended early by a NUL. Each result word carries its kind in tuser, the
// command byte in tdata (zero for other kinds) and tlast on the final
// result caused by one input byte. One byte is taken per cycle unless the
// output stalls; a byte with two or three results (frame end) holds tready
// low until they drain from the single output register, one per ready cycle.
// max_length (APB offset 0x0, reset 1024) bounds the accepted frame length
// and should only be written while the stream is idle.
module length_framed_command_deframer
  import lfcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] chunk_start
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_len;
  logic        fire;
  logic        can_load;
  grp_t        grp;
  res_t        res;

  // a new byte goes in when the output register is free or frees this cycle
  assign s_axis_tready = can_load;
  assign fire          = s_axis_tvalid & can_load;

  lfcd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // frame parser: state registers plus the result group for one byte
  lfcd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_i        (s_axis_tdata),
    .chunk_start_i (s_axis_tuser[0]),
    .max_len_i     (max_len),
    .grp_o         (grp)
  );

  // result register, drained one word per cycle while m_axis_tready is high
  lfcd_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .grp_i      (grp),
    .can_load_o (can_load),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_res_o    (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== design/lfcd_cfg.sv =====
module lfcd_cfg
  import lfcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_len_o
);

  logic [15:0] max_len_q, max_len_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == 1'b0);

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ResetMaxLen;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata    = (paddr[2] == 1'b0) ? {16'd0, max_len_q} : 32'd0;
  assign max_len_o = max_len_q;

endmodule

// ===== design/lfcd_core.sv =====
module lfcd_core
  import lfcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  data_i,
  input  logic        chunk_start_i,
  input  logic [15:0] max_len_i,
  output grp_t        grp_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic        tok_q, tok_d;
  logic        ended_q, ended_d;
  logic        text_q, text_d;

  always_comb begin
    logic [1:0]  n;
    logic [15:0] len;
    logic [15:0] left_dec;
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    left_d   = left_q;
    tok_d    = tok_q;
    ended_d  = ended_q;
    text_d   = text_q;
    grp_o    = '0;
    n        = 2'd0;
    len      = {len_hi_q, data_i};
    left_dec = left_q - 16'd1;

    if (chunk_start_i && data_i == StartByte) begin
      // forced resync: an open frame is dropped
      if (phase_q != PH_IDLE) begin
        grp_o.slot[n].kind = KIND_TRUNC;
        n = n + 2'd1;
      end
      left_d  = '0;
      tok_d   = 1'b0;
      ended_d = 1'b0;
      text_d  = 1'b0;
      phase_d = PH_LEN_HI;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (data_i == StartByte) begin
            left_d  = '0;
            tok_d   = 1'b0;
            ended_d = 1'b0;
            text_d  = 1'b0;
            phase_d = PH_LEN_HI;
          end else begin
            grp_o.slot[n].kind = KIND_BAD_START;
            n = n + 2'd1;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = data_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len < HeaderLen || len > max_len_i) begin
            grp_o.slot[n].kind = KIND_BAD_LEN;
            n = n + 2'd1;
            phase_d = PH_IDLE;
          end else if (len == HeaderLen) begin
            phase_d = PH_IDLE;
          end else begin
            left_d  = len - HeaderLen;
            tok_d   = 1'b0;
            ended_d = 1'b0;
            text_d  = 1'b0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (!ended_q) begin
            if (data_i == NulByte) begin
              ended_d = 1'b0 | 1'b1;
              if (tok_q) begin
                grp_o.slot[n].kind = KIND_CMD_END;
                n = n + 2'd1;
              end
              tok_d = 1'b0;
            end else begin
              text_d = 1'b1;
              if (data_i == SepByte) begin
                if (tok_q) begin
                  grp_o.slot[n].kind = KIND_CMD_END;
                  n = n + 2'd1;
                end
                tok_d = 1'b0;
              end else begin
                grp_o.slot[n].kind = KIND_CMD_BYTE;
                grp_o.slot[n].data = data_i;
                n = n + 2'd1;
                tok_d = 1'b1;
              end
            end
          end
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            if (tok_d) begin
              grp_o.slot[n].kind = KIND_CMD_END;
              n = n + 2'd1;
            end
            if (text_d) begin
              grp_o.slot[n].kind = KIND_DONE;
              n = n + 2'd1;
            end
            left_d  = '0;
            tok_d   = 1'b0;
            ended_d = 1'b0;
            text_d  = 1'b0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (n != 2'd0) begin
      grp_o.slot[n - 2'd1].last = 1'b1;
    end
    grp_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      len_hi_q <= '0;
      left_q   <= '0;
      tok_q    <= 1'b0;
      ended_q  <= 1'b0;
      text_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      tok_q    <= tok_d;
      ended_q  <= ended_d;
      text_q   <= text_d;
    end
  end

endmodule

// ===== design/lfcd_obuf.sv =====
module lfcd_obuf
  import lfcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  grp_t       grp_i,
  output logic       can_load_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output res_t       m_res_o
);

  res_t [MaxResults-1:0] ent_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            idx_q, idx_d;
  logic                  pop;
  logic                  load;

  assign m_valid_o  = (cnt_q != 2'd0);
  assign pop        = m_valid_o & m_ready_i;
  assign can_load_o = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & pop);
  assign load       = fire_i & (grp_i.count != 2'd0);
  assign m_res_o    = ent_q[idx_q];

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load) begin
      cnt_d = grp_i.count;
      idx_d = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= grp_i.slot;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || idx_q == 2'd0)
    else $error("output group overruns its slots");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + {1'b0, cnt_q}) <= 3'd3)
    else $error("read index past loaded group");

  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_res_o.last |-> cnt_q == 2'd1)
    else $error("last flag before final result of a word");

  a_drain_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cnt_q > 2'd1 |=> m_valid_o)
    else $error("pending results dropped");

  a_no_lost_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> can_load_o)
    else $error("group loaded over undelivered results");
`endif

endmodule
